// ----- sv/tlpc_pkg.sv -----
// ----------------------------------------------------------------------------
// tlpc_pkg
// Shared types, register map, reset values and lamp/segment codes of the
// four-phase traffic light controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpc_pkg;

   // Configuration register map (byte addresses 4*i)
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0]  REG_TICKS_PER_SECOND = 2'd0;
   localparam logic [1:0]  REG_CYCLE_SECONDS    = 2'd1;
   localparam logic [1:0]  REG_YELLOW_SECONDS   = 2'd2;

   // Reset values of the registers and the counters
   localparam logic [7:0] TICKS_PER_SECOND_RST = 8'd20;
   localparam logic [6:0] CYCLE_SECONDS_RST    = 7'd30;
   localparam logic [6:0] YELLOW_SECONDS_RST   = 7'd2;

   typedef enum logic [1:0] {
      PH_NS_GREEN  = 2'd0,
      PH_NS_YELLOW = 2'd1,
      PH_EW_GREEN  = 2'd2,
      PH_EW_YELLOW = 2'd3
   } phase_type;

   // Lamp codes: bit0 red, bit1 yellow, bit2 green
   localparam logic [2:0] LAMP_RED    = 3'b001;
   localparam logic [2:0] LAMP_YELLOW = 3'b010;
   localparam logic [2:0] LAMP_GREEN  = 3'b100;

   typedef struct packed {
      logic [6:0] tens;
      logic [6:0] ones;
   } seg_pair_type;

   // Seven-segment pattern of one decimal digit, bit0 is segment a.
   // Digits above nine show blank.
   function automatic logic [6:0] digit_seg(input logic [3:0] digit);
      logic [6:0] seg;
      case (digit)
         4'd0:    seg = 7'h3f;
         4'd1:    seg = 7'h06;
         4'd2:    seg = 7'h5b;
         4'd3:    seg = 7'h4f;
         4'd4:    seg = 7'h66;
         4'd5:    seg = 7'h6d;
         4'd6:    seg = 7'h7d;
         4'd7:    seg = 7'h07;
         4'd8:    seg = 7'h7f;
         4'd9:    seg = 7'h6f;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

// ----- sv/tlpc_seg_decode.sv -----
// ----------------------------------------------------------------------------
// tlpc_seg_decode
// Splits a 7-bit count into tens and ones digits and encodes both as
// seven-segment patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpc_seg_decode
   import tlpc_pkg::*;
(
   input  wire logic [6:0]   count,
   output seg_pair_type      segs
);

   logic [14:0] recip_prod;
   logic [3:0]  tens;
   logic [6:0]  tens_x10;
   logic [6:0]  ones_wide;

   // count / 10 as count * 205 >> 11, exact for every 7-bit count
   assign recip_prod = 15'(count) * 15'd205;
   assign tens       = recip_prod[14:11];
   assign tens_x10   = {tens, 3'b000} - 7'({tens, 1'b0}) + 7'({tens, 2'b00});
   assign ones_wide  = count - tens_x10;

   // tens in the upper member, ones in the lower
   assign segs = {digit_seg(tens), digit_seg(ones_wide[3:0])};

endmodule

`default_nettype wire

// ----- sv/traffic_light_phase_controller_top.sv -----
// ----------------------------------------------------------------------------
// traffic_light_phase_controller_top
// Four-phase traffic light controller: tick prescaler, countdown, phase
// sequencing, lamp drive and seven-segment count display.
// ----------------------------------------------------------------------------
// Usage
//  - Request channel (req_valid/req_ready, req_tick): one request per timer
//    period; req_tick = 1 advances the prescaler, 0 lets no time pass.
//  - Response channel (rsp_valid/rsp_ready): exactly one response per
//    request, in order, showing phase, lamps, counts and segment patterns
//    after that request has been applied.
//  - CSR port (APB style, pready tied high): ticks_per_second at 0x0,
//    cycle_seconds at 0x4, yellow_seconds at 0x8. Write only while idle.
//  - Path: a request is held in the request register, then moves into the
//    response register once that register is empty or being emptied.
//    Throughput: one request per clock while responses are taken, set by the
//    request register feeding the state update and the response register.
//  - Stall: while the response waits, one further request is still taken
//    into the request register; only then does req_ready drop.
//  - Reset (synchronous, active high): registers to 20/30/2, prescaler to 0,
//    seconds to 30, phase to north-south green, both stages emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module traffic_light_phase_controller_top
   import tlpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_tick,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [1:0]                 rsp_phase,
   output logic [2:0]                 rsp_ew_lamps,
   output logic [2:0]                 rsp_ns_lamps,
   output logic [6:0]                 rsp_ew_count,
   output logic [6:0]                 rsp_ns_count,
   output logic [6:0]                 rsp_ew_tens_seg,
   output logic [6:0]                 rsp_ew_ones_seg,
   output logic [6:0]                 rsp_ns_tens_seg,
   output logic [6:0]                 rsp_ns_ones_seg,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   // ---------------------------------------------------------------- CSRs
   logic [7:0] tps_ff;
   logic [6:0] cycle_ff;
   logic [6:0] yellow_ff;
   logic       csr_wr;
   logic [1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff    <= TICKS_PER_SECOND_RST;
         cycle_ff  <= CYCLE_SECONDS_RST;
         yellow_ff <= YELLOW_SECONDS_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_TICKS_PER_SECOND: tps_ff    <= csr_pwdata[7:0];
            REG_CYCLE_SECONDS:    cycle_ff  <= csr_pwdata[6:0];
            REG_YELLOW_SECONDS:   yellow_ff <= csr_pwdata[6:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_TICKS_PER_SECOND: csr_prdata = {24'd0, tps_ff};
         REG_CYCLE_SECONDS:    csr_prdata = {25'd0, cycle_ff};
         REG_YELLOW_SECONDS:   csr_prdata = {25'd0, yellow_ff};
         default:              csr_prdata = 32'd0;
      endcase
   end

   // ------------------------------------------------------ request stage
   logic s1_valid_ff, s1_valid_in;
   logic s1_tick_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;

   // Move the held request into the response register when that register
   // is empty or its content is being taken this cycle.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (advance)
         s1_valid_in = 1'b0;
      if (req_valid && req_ready)
         s1_valid_in = 1'b1;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready)
         rsp_valid_in = 1'b0;
      if (advance)
         rsp_valid_in = 1'b1;
   end

   // -------------------------------------------------- counters and phase
   logic [7:0] tick_count_ff, tick_count_in;
   logic [6:0] seconds_ff, seconds_in;
   phase_type  phase_ff, phase_in;
   logic [7:0] tick_inc;
   logic       second_done;
   logic [6:0] sec_dec;
   logic [6:0] sec_reload;
   phase_type  phase_mid;

   assign tick_inc    = tick_count_ff + 8'd1;
   assign second_done = s1_tick_ff && (tick_inc == tps_ff);
   assign sec_dec     = seconds_ff - 7'd1;
   assign sec_reload  = (sec_dec == 7'd0) ? cycle_ff : sec_dec;
   assign phase_mid   = (sec_dec == 7'd0) ? phase_type'(phase_ff + 2'd1) : phase_ff;

   always_comb begin
      tick_count_in = tick_count_ff;
      seconds_in    = seconds_ff;
      phase_in      = phase_ff;
      if (s1_tick_ff) begin
         tick_count_in = second_done ? 8'd0 : tick_inc;
      end
      if (second_done) begin
         // reload at zero advances the phase, reaching yellow time advances again
         seconds_in = sec_reload;
         phase_in   = (sec_reload == yellow_ff) ? phase_type'(phase_mid + 2'd1) : phase_mid;
      end
   end

   // ---------------------------------------------------- display values
   logic [2:0]   ew_lamps_in, ns_lamps_in;
   logic [6:0]   ew_count_in, ns_count_in;
   logic [6:0]   green_count;
   seg_pair_type ew_segs, ns_segs;

   // green side shows time to its yellow, red side the full remainder
   assign green_count = (seconds_in > yellow_ff) ? (seconds_in - yellow_ff) : seconds_in;

   always_comb begin
      case (phase_in)
         PH_NS_GREEN: begin
            ns_lamps_in = LAMP_GREEN;
            ew_lamps_in = LAMP_RED;
         end
         PH_NS_YELLOW: begin
            ns_lamps_in = LAMP_YELLOW;
            ew_lamps_in = LAMP_RED;
         end
         PH_EW_GREEN: begin
            ns_lamps_in = LAMP_RED;
            ew_lamps_in = LAMP_GREEN;
         end
         default: begin
            ns_lamps_in = LAMP_RED;
            ew_lamps_in = LAMP_YELLOW;
         end
      endcase

      if (phase_in inside {PH_NS_GREEN, PH_NS_YELLOW}) begin
         ew_count_in = seconds_in;
         ns_count_in = green_count;
      end else begin
         ns_count_in = seconds_in;
         ew_count_in = green_count;
      end
   end

   tlpc_seg_decode u_ew_seg (
      .count (ew_count_in),
      .segs  (ew_segs)
   );

   tlpc_seg_decode u_ns_seg (
      .count (ns_count_in),
      .segs  (ns_segs)
   );

   // ----------------------------------------------------- registers
   logic [1:0]   rsp_phase_ff;
   logic [2:0]   rsp_ew_lamps_ff, rsp_ns_lamps_ff;
   logic [6:0]   rsp_ew_count_ff, rsp_ns_count_ff;
   seg_pair_type rsp_ew_segs_ff, rsp_ns_segs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tick_count_ff <= 8'd0;
         seconds_ff    <= CYCLE_SECONDS_RST;
         phase_ff      <= PH_NS_GREEN;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            tick_count_ff <= tick_count_in;
            seconds_ff    <= seconds_in;
            phase_ff      <= phase_in;
         end
      end
   end

   // payload: hold the request tick and the response fields, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready)
         s1_tick_ff <= req_tick;
      if (advance) begin
         rsp_phase_ff    <= phase_in;
         rsp_ew_lamps_ff <= ew_lamps_in;
         rsp_ns_lamps_ff <= ns_lamps_in;
         rsp_ew_count_ff <= ew_count_in;
         rsp_ns_count_ff <= ns_count_in;
         rsp_ew_segs_ff  <= ew_segs;
         rsp_ns_segs_ff  <= ns_segs;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_phase       = rsp_phase_ff;
   assign rsp_ew_lamps    = rsp_ew_lamps_ff;
   assign rsp_ns_lamps    = rsp_ns_lamps_ff;
   assign rsp_ew_count    = rsp_ew_count_ff;
   assign rsp_ns_count    = rsp_ns_count_ff;
   assign rsp_ew_tens_seg = rsp_ew_segs_ff.tens;
   assign rsp_ew_ones_seg = rsp_ew_segs_ff.ones;
   assign rsp_ns_tens_seg = rsp_ns_segs_ff.tens;
   assign rsp_ns_ones_seg = rsp_ns_segs_ff.ones;

endmodule

`default_nettype wire

// ----- sv/tlpc_checker.sv -----
// ----------------------------------------------------------------------------
// tlpc_checker
// Port-level checks of the traffic light controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpc_checker
   import tlpc_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [1:0]            rsp_phase,
   input wire logic [2:0]            rsp_ew_lamps,
   input wire logic [2:0]            rsp_ns_lamps,
   input wire logic [6:0]            rsp_ew_count,
   input wire logic [6:0]            rsp_ns_count
);

   // exactly one direction shows red, each side lights one lamp
   a_one_red: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_ns_lamps == LAMP_RED) != (rsp_ew_lamps == LAMP_RED))
         && $onehot(rsp_ns_lamps) && $onehot(rsp_ew_lamps))
      else $error("lamp pattern inconsistent");

   // east-west shows red in both north-south phases
   a_phase_lamps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase == PH_NS_GREEN || rsp_phase == PH_NS_YELLOW)
         |-> rsp_ew_lamps == LAMP_RED)
      else $error("east-west not red in a north-south phase");

   // in the east-west phases the east-west count never exceeds the north-south count
   a_count_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase == PH_EW_GREEN || rsp_phase == PH_EW_YELLOW)
         |-> rsp_ew_count <= rsp_ns_count)
      else $error("green count above red count");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_phase)
         && $stable(rsp_ew_count) && $stable(rsp_ns_count))
      else $error("stalled response changed");

endmodule

bind traffic_light_phase_controller_top tlpc_checker u_tlpc_checker (.*);

`default_nettype wire

// ----- bench/traffic_light_phase_controller_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// traffic_light_phase_controller_top_tb
// Self-checking bench for the four-phase traffic light controller. It streams
// timer tick requests through the valid/ready channel and predicts every
// displayed state (phase, lamps, counts, segment patterns) from its own
// prescaler, countdown and phase model. It reprograms the timing registers
// over the CSR port between bursts, reads them back, and stalls both channels
// at random.
// ----------------------------------------------------------------------------

module traffic_light_phase_controller_top_tb;
   import tlpc_pkg::*;

   // Silence limit: cycles with no request or response accepted
   localparam int unsigned STALL_LIMIT  = 200;
   localparam int unsigned TARGET_ITEMS = 1900;

   // One displayed state, as the response channel presents it
   typedef struct {
      phase_type  phase;
      logic [2:0] ew_lamps;
      logic [2:0] ns_lamps;
      logic [6:0] ew_count;
      logic [6:0] ns_count;
      logic [6:0] ew_tens_seg;
      logic [6:0] ew_ones_seg;
      logic [6:0] ns_tens_seg;
      logic [6:0] ns_ones_seg;
   } display_type;

   // -------------------------------------------------------------------------
   // Light state tracker: mirrors the prescaler, the countdown and the phase,
   // and holds the displays still owed by the block, oldest first.
   // -------------------------------------------------------------------------
   class light_state_tracker;
      logic [7:0]  ticks_per_second;
      logic [6:0]  cycle_seconds;
      logic [6:0]  yellow_seconds;
      logic [7:0]  tick_count;
      logic [6:0]  seconds_left;
      phase_type   phase;
      display_type pending_displays[$];
      int unsigned failures;

      function new();
         ticks_per_second = TICKS_PER_SECOND_RST;
         cycle_seconds    = CYCLE_SECONDS_RST;
         yellow_seconds   = YELLOW_SECONDS_RST;
         tick_count       = '0;
         seconds_left     = CYCLE_SECONDS_RST;
         phase            = PH_NS_GREEN;
         failures         = 0;
      endfunction

      function void write_register(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_TICKS_PER_SECOND: ticks_per_second = value[7:0];
            REG_CYCLE_SECONDS:    cycle_seconds    = value[6:0];
            REG_YELLOW_SECONDS:   yellow_seconds   = value[6:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] register_value(logic [1:0] idx);
         logic [31:0] value;
         case (idx)
            REG_TICKS_PER_SECOND: value = {24'd0, ticks_per_second};
            REG_CYCLE_SECONDS:    value = {25'd0, cycle_seconds};
            default:              value = {25'd0, yellow_seconds};
         endcase
         return value;
      endfunction

      static function logic [6:0] segment_pattern(int unsigned digit);
         logic [6:0] pattern;
         case (digit)
            0: pattern = 7'h3f;
            1: pattern = 7'h06;
            2: pattern = 7'h5b;
            3: pattern = 7'h4f;
            4: pattern = 7'h66;
            5: pattern = 7'h6d;
            6: pattern = 7'h7d;
            7: pattern = 7'h07;
            8: pattern = 7'h7f;
            9: pattern = 7'h6f;
            default: pattern = 7'h00;
         endcase
         return pattern;
      endfunction

      // Apply one accepted request and queue the display it produces.
      function void note_request(logic tick);
         display_type shown;
         logic [6:0]  green_side;
         int unsigned ew_c;
         int unsigned ns_c;
         if (tick) begin
            tick_count = tick_count + 8'd1;
            if (tick_count == ticks_per_second) begin
               tick_count   = '0;
               seconds_left = seconds_left - 7'd1;
               if (seconds_left == 7'd0) begin
                  seconds_left = cycle_seconds;
                  phase        = phase_type'(phase + 2'd1);
               end
               if (seconds_left == yellow_seconds)
                  phase = phase_type'(phase + 2'd1);
            end
         end
         green_side = (seconds_left > yellow_seconds) ? seconds_left - yellow_seconds
                                                      : seconds_left;
         shown.phase = phase;
         case (phase)
            PH_NS_GREEN:  begin shown.ns_lamps = LAMP_GREEN;  shown.ew_lamps = LAMP_RED;    end
            PH_NS_YELLOW: begin shown.ns_lamps = LAMP_YELLOW; shown.ew_lamps = LAMP_RED;    end
            PH_EW_GREEN:  begin shown.ns_lamps = LAMP_RED;    shown.ew_lamps = LAMP_GREEN;  end
            default:      begin shown.ns_lamps = LAMP_RED;    shown.ew_lamps = LAMP_YELLOW; end
         endcase
         if (phase == PH_NS_GREEN || phase == PH_NS_YELLOW) begin
            shown.ew_count = seconds_left;
            shown.ns_count = green_side;
         end else begin
            shown.ns_count = seconds_left;
            shown.ew_count = green_side;
         end
         ew_c = shown.ew_count;
         ns_c = shown.ns_count;
         shown.ew_tens_seg = segment_pattern(ew_c / 10);
         shown.ew_ones_seg = segment_pattern(ew_c % 10);
         shown.ns_tens_seg = segment_pattern(ns_c / 10);
         shown.ns_ones_seg = segment_pattern(ns_c % 10);
         pending_displays.push_back(shown);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      // Compare one accepted response with the oldest owed display.
      function void check_display(display_type got);
         display_type want;
         if (pending_displays.size() == 0) begin
            $error("response with no request outstanding");
            failures++;
            return;
         end
         want = pending_displays.pop_front();
         compare_field("phase",       want.phase,       got.phase);
         compare_field("ew_lamps",    want.ew_lamps,    got.ew_lamps);
         compare_field("ns_lamps",    want.ns_lamps,    got.ns_lamps);
         compare_field("ew_count",    want.ew_count,    got.ew_count);
         compare_field("ns_count",    want.ns_count,    got.ns_count);
         compare_field("ew_tens_seg", want.ew_tens_seg, got.ew_tens_seg);
         compare_field("ew_ones_seg", want.ew_ones_seg, got.ew_ones_seg);
         compare_field("ns_tens_seg", want.ns_tens_seg, got.ns_tens_seg);
         compare_field("ns_ones_seg", want.ns_ones_seg, got.ns_ones_seg);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block inputs, all known from time zero
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid   = 1'b0;
   logic                  req_tick    = 1'b0;
   logic                  rsp_ready   = 1'b0;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;

   logic        req_ready;
   logic        rsp_valid;
   logic [1:0]  rsp_phase;
   logic [2:0]  rsp_ew_lamps;
   logic [2:0]  rsp_ns_lamps;
   logic [6:0]  rsp_ew_count;
   logic [6:0]  rsp_ns_count;
   logic [6:0]  rsp_ew_tens_seg;
   logic [6:0]  rsp_ew_ones_seg;
   logic [6:0]  rsp_ns_tens_seg;
   logic [6:0]  rsp_ns_ones_seg;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   light_state_tracker tracker = new();

   // Whether the response side stalls between responses in this burst
   logic        rsp_stalls    = 1'b0;
   int unsigned stall_left    = 0;
   int unsigned rsp_hold      = 0;
   int unsigned quiet_cycles  = 0;
   int unsigned requests_sent = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   traffic_light_phase_controller_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_tick        (req_tick),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_phase       (rsp_phase),
      .rsp_ew_lamps    (rsp_ew_lamps),
      .rsp_ns_lamps    (rsp_ns_lamps),
      .rsp_ew_count    (rsp_ew_count),
      .rsp_ns_count    (rsp_ns_count),
      .rsp_ew_tens_seg (rsp_ew_tens_seg),
      .rsp_ew_ones_seg (rsp_ew_ones_seg),
      .rsp_ns_tens_seg (rsp_ns_tens_seg),
      .rsp_ns_ones_seg (rsp_ns_ones_seg),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // -------------------------------------------------------------------------
   // Response side: check each accepted response, then, in a burst that stalls,
   // hold ready low for a drawn number of cycles, possibly none, before taking the next one.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      display_type got;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && rsp_ready) begin
         got.phase       = phase_type'(rsp_phase);
         got.ew_lamps    = rsp_ew_lamps;
         got.ns_lamps    = rsp_ns_lamps;
         got.ew_count    = rsp_ew_count;
         got.ns_count    = rsp_ns_count;
         got.ew_tens_seg = rsp_ew_tens_seg;
         got.ew_ones_seg = rsp_ew_ones_seg;
         got.ns_tens_seg = rsp_ns_tens_seg;
         got.ns_ones_seg = rsp_ns_ones_seg;
         tracker.check_display(got);
         rsp_hold = rsp_stalls ? $urandom_range(0, 4) : 0;
         if (rsp_hold != 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= rsp_hold - 1;
         end
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: end the run if neither channel moves for too long
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Offer one tick request after an optional gap and hold it until taken.
   // Valid is dropped only when a gap follows, so back-to-back requests keep
   // it high without a glitch.
   task automatic send_request(input logic tick, input logic gaps);
      int unsigned gap;
      gap = gaps ? $urandom_range(0, 4) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_tick  <= tick;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(tick);
      requests_sent++;
   endtask

   // Drop valid and wait until every owed response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_displays.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // One APB transfer: setup cycle, then access until pready.
   task automatic csr_access(input logic write, input logic [1:0] idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
   endtask

   // Write all three timing registers, junk in the unused upper bits, then
   // read each one back. Only call with the block idle.
   task automatic program_timing(input logic [7:0] tps, input logic [6:0] cyc,
                                 input logic [6:0] yel);
      logic [31:0] values [3];
      logic [31:0] rdata;
      logic [1:0]  idx;
      values[REG_TICKS_PER_SECOND] = {24'($urandom_range(0, 2**24 - 1)), tps};
      values[REG_CYCLE_SECONDS]    = {25'($urandom_range(0, 2**25 - 1)), cyc};
      values[REG_YELLOW_SECONDS]   = {25'($urandom_range(0, 2**25 - 1)), yel};
      for (int i = 0; i < 3; i++) begin
         idx = 2'(i);
         csr_access(1'b1, idx, values[i], rdata);
         tracker.write_register(idx, values[i]);
      end
      for (int i = 0; i < 3; i++) begin
         idx = 2'(i);
         csr_access(1'b0, idx, '0, rdata);
         tracker.compare_field("csr readback", tracker.register_value(idx), rdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // One burst: reprogram while idle, pick the idling style, then stream
   // requests that are mostly ticks with some idle periods mixed in.
   task automatic run_burst(input logic [7:0] tps, input logic [6:0] cyc,
                            input logic [6:0] yel, input int unsigned count,
                            input int unsigned tick_pct);
      logic gaps;
      drain_responses();
      program_timing(tps, cyc, yel);
      gaps       = $urandom_range(0, 3) != 0;
      rsp_stalls <= $urandom_range(0, 3) != 0;
      for (int unsigned i = 0; i < count; i++)
         send_request($urandom_range(1, 100) <= tick_pct, gaps);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      logic [7:0]  tps;
      logic [6:0]  cyc;
      logic [6:0]  yel;
      int unsigned pick;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset timing, an idle period, twenty ticks to reach the
      // first second boundary, then one more of each.
      send_request(1'b0, 1'b0);
      repeat (20) send_request(1'b1, 1'b0);
      send_request(1'b0, 1'b0);
      send_request(1'b1, 1'b0);

      // Short cycle, so every phase and both reloads come quickly
      run_burst(8'd1, 7'd3, 7'd1, 60, 95);
      // Yellow equal to the cycle: reload and yellow advance in one step
      run_burst(8'd1, 7'd4, 7'd4, 40, 95);
      // Zero ticks per second: a second every 256 ticks
      run_burst(8'd0, 7'd3, 7'd1, 300, 95);
      // Prescaler at 255 with the widest cycle and yellow
      run_burst(8'd255, 7'd127, 7'd127, 300, 95);
      // Prescaler lowered below its count, then a zero cycle length wraps
      // the countdown to 127 and shows counts above 99
      run_burst(8'd1, 7'd0, 7'd0, 300, 95);
      // Widest display range within two digits
      run_burst(8'd2, 7'd99, 7'd98, 80, 90);

      // Random bursts, mostly fast prescalers and short cycles so the phase
      // sequence turns over many times
      while (requests_sent < TARGET_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 7)
            tps = 8'($urandom_range(1, 3));
         else if (pick < 9)
            tps = 8'($urandom_range(4, 12));
         else
            tps = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 4) != 0)
            cyc = 7'($urandom_range(3, 15));
         else
            cyc = 7'($urandom_range(0, 127));
         if ($urandom_range(0, 4) != 0 && cyc >= 2)
            yel = 7'($urandom_range(1, cyc - 1));
         else
            yel = 7'($urandom_range(0, 127));
         run_burst(tps, cyc, yel, (tps == 0 || tps > 12) ? 300 : 80, 90);
      end

      drain_responses();
      repeat (4) @(posedge clock);
      if (tracker.failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- traffic_light_phase_controller_top.f -----
sv/tlpc_pkg.sv
sv/tlpc_seg_decode.sv
sv/traffic_light_phase_controller_top.sv
sv/tlpc_checker.sv
bench/traffic_light_phase_controller_top_tb.sv
